FILE: src/rfd_pkg.sv
`default_nettype none

package rfd_pkg;

  // Configuration register indexes, word addressed on the APB port.
  localparam logic [1:0] REG_NODE_ADDRESS       = 2'd0;
  localparam logic [1:0] REG_PROMISCUOUS        = 2'd1;
  localparam logic [1:0] REG_BROADCAST_ADDRESS  = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD_LENGTH = 2'd3;

  localparam logic [7:0] NODE_ADDRESS_RESET       = 8'd0;
  localparam logic       PROMISCUOUS_RESET        = 1'b0;
  localparam logic [7:0] BROADCAST_ADDRESS_RESET  = 8'd255;
  localparam logic [7:0] MAX_PAYLOAD_LENGTH_RESET = 8'd66;

  // Result kinds.
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  // Control byte flags.
  localparam logic [7:0] CTL_IS_ACK     = 8'h80;
  localparam logic [7:0] CTL_ACK_WANTED = 8'h40;

  // Smallest length byte that still covers target, sender and control.
  localparam logic [7:0] HEADER_BYTES = 8'd3;

  typedef struct packed {
    logic [7:0] node_address;
    logic       promiscuous;
    logic [7:0] broadcast_address;
    logic [7:0] max_payload_length;
  } rfd_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] data_length;
    logic [7:0] target_id;
    logic [7:0] sender_id;
    logic       is_ack;
    logic       ack_wanted;
    logic       ack_reply_due;
    logic       last_of_frame;
  } rfd_result_t;

endpackage

`default_nettype wire

FILE: src/rfd_cfg.sv
`default_nettype none

module rfd_cfg
  import rfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  output      rfd_cfg_t    cfg_o
);

  rfd_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_address       <= NODE_ADDRESS_RESET;
      cfg_q.promiscuous        <= PROMISCUOUS_RESET;
      cfg_q.broadcast_address  <= BROADCAST_ADDRESS_RESET;
      cfg_q.max_payload_length <= MAX_PAYLOAD_LENGTH_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NODE_ADDRESS:       cfg_q.node_address       <= pwdata[7:0];
        REG_PROMISCUOUS:        cfg_q.promiscuous        <= pwdata[0];
        REG_BROADCAST_ADDRESS:  cfg_q.broadcast_address  <= pwdata[7:0];
        REG_MAX_PAYLOAD_LENGTH: cfg_q.max_payload_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_NODE_ADDRESS:       prdata = {24'd0, cfg_q.node_address};
      REG_PROMISCUOUS:        prdata = {31'd0, cfg_q.promiscuous};
      REG_BROADCAST_ADDRESS:  prdata = {24'd0, cfg_q.broadcast_address};
      REG_MAX_PAYLOAD_LENGTH: prdata = {24'd0, cfg_q.max_payload_length};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/radio_frame_rx_deframer_unit.sv
`default_nettype none

// Receive deframer for a small packet radio link. Bytes from the receive FIFO
// enter one item per clock while in_ready_o is high; frame_start_i marks the
// length byte of each frame. The block emits at most one result per input item:
// a drop result at the target byte when the frame is too short or not for this
// node, a header result after the control byte, and then one data result per
// payload byte with its index and a last mark. An accepted item is held in an
// input register; when the result register is free or being emptied, the
// parser updates its state from it and loads the result register, and the
// block sustains one item per clock while results are taken. The input
// register keeps taking items while a result waits in the result register, as
// long as that stage can drain; only a held result together with a pending
// input item stalls in_ready_o. Configuration is written through the APB port
// (node address, promiscuous flag, broadcast address, length clamp at byte
// addresses 0, 4, 8 and 12) and should change only while no frame is in flight.

module radio_frame_rx_deframer_unit
  import rfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  // Input channel.
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_start_i,
  // Result channel.
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [1:0]  kind_o,
  output      logic [7:0]  data_byte_o,
  output      logic [7:0]  byte_index_o,
  output      logic [7:0]  data_length_o,
  output      logic [7:0]  target_id_o,
  output      logic [7:0]  sender_id_o,
  output      logic        is_ack_o,
  output      logic        ack_wanted_o,
  output      logic        ack_reply_due_o,
  output      logic        last_of_frame_o
);

  // Parser phases.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_TARGET  = 3'd1;
  localparam logic [2:0] PH_SENDER  = 3'd2;
  localparam logic [2:0] PH_CONTROL = 3'd3;
  localparam logic [2:0] PH_DATA    = 3'd4;

  rfd_cfg_t cfg;

  rfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register stage.
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       start_q;

  // Result register stage.
  logic        out_vld_q;
  logic        out_vld_d;
  rfd_result_t res_q;
  rfd_result_t res_d;

  // Parser state.
  logic [2:0] phase_q, phase_d;
  logic [7:0] clen_q, clen_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] tgt_q, tgt_d;
  logic [7:0] snd_q, snd_d;

  logic       advance;
  logic       has_result;
  logic [7:0] dlen;
  logic [8:0] pos_inc;
  logic       addr_ok;
  logic       data_last;

  // The item in the input register is processed when the result register is
  // free or is being emptied in this cycle.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= rx_byte_i;
      start_q <= frame_start_i;
    end
  end

  assign dlen      = clen_q - HEADER_BYTES;
  assign pos_inc   = {1'b0, pos_q} + 9'd1;
  assign data_last = pos_inc >= {1'b0, dlen};
  assign addr_ok   = cfg.promiscuous || (byte_q == cfg.node_address) ||
                     (byte_q == cfg.broadcast_address);

  // One parsing step for the byte in the input register.
  always_comb begin
    phase_d    = phase_q;
    clen_d     = clen_q;
    pos_d      = pos_q;
    tgt_d      = tgt_q;
    snd_d      = snd_q;
    has_result = 1'b0;
    res_d      = '0;

    if (start_q) begin
      // A frame start always begins a new frame, abandoning any partial one.
      clen_d  = (byte_q > cfg.max_payload_length) ? cfg.max_payload_length : byte_q;
      pos_d   = '0;
      tgt_d   = '0;
      snd_d   = '0;
      phase_d = PH_TARGET;
    end else begin
      case (phase_q)
        PH_TARGET: begin
          tgt_d = byte_q;
          if (!addr_ok || (clen_q < HEADER_BYTES)) begin
            phase_d             = PH_IDLE;
            has_result          = 1'b1;
            res_d.kind          = KIND_DROP;
            res_d.target_id     = byte_q;
            res_d.last_of_frame = 1'b1;
          end else begin
            phase_d = PH_SENDER;
          end
        end
        PH_SENDER: begin
          snd_d   = byte_q;
          phase_d = PH_CONTROL;
        end
        PH_CONTROL: begin
          pos_d               = '0;
          phase_d             = (dlen != 8'd0) ? PH_DATA : PH_IDLE;
          has_result          = 1'b1;
          res_d.kind          = KIND_HEADER;
          res_d.data_length   = dlen;
          res_d.target_id     = tgt_q;
          res_d.sender_id     = snd_q;
          res_d.is_ack        = |(byte_q & CTL_IS_ACK);
          res_d.ack_wanted    = |(byte_q & CTL_ACK_WANTED);
          res_d.ack_reply_due = |(byte_q & CTL_ACK_WANTED) &&
                                (tgt_q != cfg.broadcast_address);
          res_d.last_of_frame = (dlen == 8'd0);
        end
        PH_DATA: begin
          pos_d               = pos_inc[7:0];
          phase_d             = data_last ? PH_IDLE : PH_DATA;
          has_result          = 1'b1;
          res_d.kind          = KIND_DATA;
          res_d.data_byte     = byte_q;
          res_d.byte_index    = pos_q;
          res_d.data_length   = dlen;
          res_d.target_id     = tgt_q;
          res_d.sender_id     = snd_q;
          res_d.last_of_frame = data_last;
        end
        default: begin
          // Idle or unused code: the byte is ignored.
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      clen_q  <= '0;
      pos_q   <= '0;
      tgt_q   <= '0;
      snd_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      clen_q  <= clen_d;
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      snd_q   <= snd_d;
    end
  end

  // The result register is loaded on an advance; otherwise it drains when taken.
  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = has_result;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = res_q.kind;
  assign data_byte_o     = res_q.data_byte;
  assign byte_index_o    = res_q.byte_index;
  assign data_length_o   = res_q.data_length;
  assign target_id_o     = res_q.target_id;
  assign sender_id_o     = res_q.sender_id;
  assign is_ack_o        = res_q.is_ack;
  assign ack_wanted_o    = res_q.ack_wanted;
  assign ack_reply_due_o = res_q.ack_reply_due;
  assign last_of_frame_o = res_q.last_of_frame;

endmodule

`default_nettype wire
